// ===== src/iqat_pkg.sv =====
// package: widths, fixed-point constants and the shared control type of the iq phase block
`default_nettype none
package iqat_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int ANGLE_W         = 16;

   localparam int REQ_DATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ANGLE_W + 7) / 8) * 8;

   localparam int PROD_W = 2 * SAMPLE_WIDTH;
   // 32*a^2 + 9*b^2 with a >= b stays below 2^(PROD_W+6)
   localparam int DEN_W  = PROD_W + 6;
   localparam int QUO_W  = ANGLE_FRAC_BITS + 1;
   localparam int ANG_CALC_W = ANGLE_FRAC_BITS + 4;
   localparam int EXT_W  = (ANG_CALC_W > ANGLE_W + 1) ? ANG_CALC_W : ANGLE_W + 1;

   // pi in q60, rounded to nearest at the angle's fraction bits
   localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] PI_FIX =
      (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
   localparam logic [63:0] HALF_PI_FIX =
      (PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);

   localparam logic [63:0] ANGLE_POS_MAX = (64'd1 << (ANGLE_W - 1)) - 64'd1;
   localparam logic [63:0] ANGLE_LIMIT   =
      (PI_FIX < ANGLE_POS_MAX) ? PI_FIX : ANGLE_POS_MAX;

   typedef struct packed {
      logic zero;
      logic q_major;
      logic neg_i;
      logic neg_q;
   } ctrl_type;

endpackage
`default_nettype wire

// ===== src/iq_phase_atan2_approximation.sv =====
// phase angle of one i/q sample pair, stall-capable pipeline with restoring divider
//
// req channel: one transfer carries one sample pair; req_tdata holds in_phase in
// the low half and quadrature above it, both two's complement.
// rsp channel: one transfer per sample, in order. rsp_tdata is the angle in
// radians, signed, ANGLE_FRAC_BITS fraction bits, in (-pi, pi]; rsp_tuser is
// the zero_vector flag, set when i = q = 0 (the angle is then 0).
// stages: magnitude stage, product stage, denominator stage, one stage per
// quotient bit of the 14-bit restoring division, output register.
// throughput: one sample per clock while rsp is not stalled; the division is
// unrolled one quotient bit per stage so nothing iterates.
// stall: each stage holds while the stage after it is full and not moving, so
// a stalled rsp fills the bubbles first and req_tready drops only when every
// stage holds an item. nothing is lost or repeated.
// reset: synchronous, clears every valid bit; the pipeline is empty after it.
`default_nettype none
module iq_phase_atan2_approximation (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [15:0] in_phase, [31:16] quadrature
   input  wire logic [iqat_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [15:0] angle
   output logic      [iqat_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] zero_vector
   output logic                                   rsp_tuser
);

   localparam int SW    = iqat_pkg::SAMPLE_WIDTH;
   localparam int PW    = iqat_pkg::PROD_W;
   localparam int DW    = iqat_pkg::DEN_W;
   localparam int QW    = iqat_pkg::QUO_W;
   localparam int XW    = iqat_pkg::EXT_W;
   localparam int AW    = iqat_pkg::ANGLE_W;

   localparam logic signed [XW-1:0] PI_X      = XW'(iqat_pkg::PI_FIX);
   localparam logic signed [XW-1:0] HALF_PI_X = XW'(iqat_pkg::HALF_PI_FIX);
   localparam logic signed [XW-1:0] SAT_HI    = XW'(iqat_pkg::ANGLE_POS_MAX);
   localparam logic signed [XW-1:0] SAT_LO    = ~SAT_HI;

   // ready chain: a stage moves when it is empty or its successor moves
   logic s1_rdy, s2_rdy, out_rdy;
   logic [QW:0] d_rdy;

   // stage 1: magnitudes and role swap
   logic                    s1_valid_ff;
   iqat_pkg::ctrl_type      s1_ctrl_ff, s1_ctrl_in;
   logic [SW-1:0]           s1_a_ff, s1_a_in, s1_b_ff, s1_b_in;

   // stage 2: products
   logic                    s2_valid_ff;
   iqat_pkg::ctrl_type      s2_ctrl_ff;
   logic [PW-1:0]           s2_aa_ff, s2_bb_ff, s2_ab_ff;

   // division stages, index 0 holds the starting remainder
   logic                    d_valid_ff [0:QW];
   iqat_pkg::ctrl_type      d_ctrl_ff  [0:QW];
   logic [DW-1:0]           d_den_ff   [0:QW];
   logic [DW-1:0]           d_rem_ff   [0:QW];
   logic [QW-1:0]           d_quo_ff   [0:QW];

   // output register
   logic                    rsp_valid_ff;
   logic [AW-1:0]           rsp_angle_ff, rsp_angle_in;
   logic                    rsp_zero_ff;

   logic [SW-1:0] raw_i, raw_q, mag_i, mag_q;

   assign out_rdy    = !rsp_valid_ff || rsp_tready;
   assign d_rdy[QW]  = !d_valid_ff[QW] || out_rdy;
   assign s2_rdy     = !s2_valid_ff || d_rdy[0];
   assign s1_rdy     = !s1_valid_ff || s2_rdy;
   assign req_tready = s1_rdy;

   for (genvar r = 0; r < QW; r++) begin : g_rdy
      assign d_rdy[r] = !d_valid_ff[r] || d_rdy[r+1];
   end

   // ---------------- stage 1
   always_comb begin
      raw_i = req_tdata[SW-1:0];
      raw_q = req_tdata[2*SW-1:SW];
      s1_ctrl_in.neg_i = raw_i[SW-1];
      s1_ctrl_in.neg_q = raw_q[SW-1];
      mag_i = raw_i[SW-1] ? (~raw_i + SW'(1)) : raw_i;
      mag_q = raw_q[SW-1] ? (~raw_q + SW'(1)) : raw_q;
      s1_ctrl_in.zero    = (mag_i == '0) && (mag_q == '0);
      s1_ctrl_in.q_major = mag_i < mag_q;
      s1_a_in = s1_ctrl_in.q_major ? mag_q : mag_i;
      s1_b_in = s1_ctrl_in.q_major ? mag_i : mag_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_valid_ff <= req_tvalid;
      end
      if (s1_rdy) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s1_a_ff    <= s1_a_in;
         s1_b_ff    <= s1_b_in;
      end
   end

   // ---------------- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_rdy) begin
         s2_ctrl_ff <= s1_ctrl_ff;
         s2_aa_ff   <= PW'(s1_a_ff) * PW'(s1_a_ff);
         s2_bb_ff   <= PW'(s1_b_ff) * PW'(s1_b_ff);
         s2_ab_ff   <= PW'(s1_a_ff) * PW'(s1_b_ff);
      end
   end

   // ---------------- stage 3: den = 32a^2 + 9b^2, rem = 32ab
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff[0] <= 1'b0;
      end else if (d_rdy[0]) begin
         d_valid_ff[0] <= s2_valid_ff;
      end
      if (d_rdy[0]) begin
         d_ctrl_ff[0] <= s2_ctrl_ff;
         d_den_ff[0]  <= (DW'(s2_aa_ff) << 5) + (DW'(s2_bb_ff) << 3) + DW'(s2_bb_ff);
         d_rem_ff[0]  <= DW'(s2_ab_ff) << 5;
         d_quo_ff[0]  <= '0;
      end
   end

   // ---------------- restoring division, one quotient bit per stage
   for (genvar j = 1; j <= QW; j++) begin : g_div
      logic [DW:0]   rem2;
      logic [DW:0]   diff;
      logic          take;
      logic [DW-1:0] rem_in;

      always_comb begin
         rem2   = {d_rem_ff[j-1], 1'b0};
         diff   = rem2 - {1'b0, d_den_ff[j-1]};
         take   = rem2 >= {1'b0, d_den_ff[j-1]};
         rem_in = take ? diff[DW-1:0] : rem2[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[j] <= 1'b0;
         end else if (d_rdy[j]) begin
            d_valid_ff[j] <= d_valid_ff[j-1];
         end
         if (d_rdy[j]) begin
            d_ctrl_ff[j] <= d_ctrl_ff[j-1];
            d_den_ff[j]  <= d_den_ff[j-1];
            d_rem_ff[j]  <= rem_in;
            d_quo_ff[j]  <= {d_quo_ff[j-1][QW-2:0], take};
         end
      end
   end

   // ---------------- rounding, octant offset and saturation
   logic [QW:0]              quo_p1;
   logic signed [XW-1:0]     t_x, st_x, ang_x;
   iqat_pkg::ctrl_type       fin_ctrl;

   always_comb begin
      fin_ctrl = d_ctrl_ff[QW];
      quo_p1   = {1'b0, d_quo_ff[QW]} + (QW+1)'(1);
      t_x      = XW'(quo_p1[QW:1]);
      st_x     = (fin_ctrl.neg_i ^ fin_ctrl.neg_q) ? -t_x : t_x;
      priority if (fin_ctrl.zero) begin
         ang_x = '0;
      end else if (fin_ctrl.q_major) begin
         ang_x = fin_ctrl.neg_q ? (-HALF_PI_X - st_x) : (HALF_PI_X - st_x);
      end else if (!fin_ctrl.neg_i) begin
         ang_x = st_x;
      end else if (!fin_ctrl.neg_q) begin
         // negative real axis lands here and gives +pi
         ang_x = PI_X + st_x;
      end else begin
         ang_x = -PI_X + st_x;
      end
      if (ang_x > SAT_HI) begin
         rsp_angle_in = SAT_HI[AW-1:0];
      end else if (ang_x < SAT_LO) begin
         rsp_angle_in = SAT_LO[AW-1:0];
      end else begin
         rsp_angle_in = ang_x[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= d_valid_ff[QW];
      end
      if (out_rdy) begin
         rsp_angle_ff <= rsp_angle_in;
         rsp_zero_ff  <= fin_ctrl.zero;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = iqat_pkg::RSP_DATA_W'(rsp_angle_ff);
   assign rsp_tuser  = rsp_zero_ff;

endmodule
`default_nettype wire

// ===== src/iqat_checker.sv =====
// port-level checks for the iq phase block, bound to its top level
`default_nettype none
module iqat_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [iqat_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser
);

   localparam int AW = iqat_pkg::ANGLE_W;
   localparam logic signed [AW:0] LIMIT = (AW+1)'(iqat_pkg::ANGLE_LIMIT);

   logic signed [AW:0] angle_x;
   assign angle_x = {rsp_tdata[AW-1], rsp_tdata[AW-1:0]};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[AW-1:0] == '0)
      else $error("zero vector with nonzero angle");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (angle_x <= LIMIT) && (angle_x >= -LIMIT))
      else $error("angle outside +-pi");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req not ready with empty output");

endmodule

bind iq_phase_atan2_approximation iqat_checker u_iqat_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ===== test/phase_checker.sv =====
// checker: predicts the phase of every accepted sample pair and compares the angle stream
module phase_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // [15:0] in_phase, [31:16] quadrature
   input  wire logic [iqat_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [15:0] angle
   input  wire logic [iqat_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] zero_vector
   input  wire logic                              rsp_tuser,
   output int                                     mismatch_count,
   output int                                     pending_count
);

   localparam int SAMPLE_WIDTH    = iqat_pkg::SAMPLE_WIDTH;
   localparam int ANGLE_W         = iqat_pkg::ANGLE_W;
   localparam int ANGLE_FRAC_BITS = iqat_pkg::ANGLE_FRAC_BITS;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               zero_vector;
   } phase_result_type;

   localparam longint PI_Q = 64'h3243_F6A8_885A_308D;
   localparam longint PI_ANGLE =
      (PI_Q + (longint'(1) << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
   localparam longint HALF_PI_ANGLE =
      (PI_Q + (longint'(1) << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
   localparam longint ANGLE_MAX = (longint'(1) << (ANGLE_W - 1)) - 1;
   localparam longint ANGLE_MIN = -(longint'(1) << (ANGLE_W - 1));

   phase_result_type angle_fifo[$];
   int               errors = 0;

   // 32ab / (32a^2 + 9b^2) with a >= b, rounded half up to the angle's fraction bits
   function automatic longint octant_ratio(longint major, longint minor);
      longint unsigned den, num;
      den = 32 * major * major + 9 * minor * minor;
      num = longint'(32 * major * minor) << (ANGLE_FRAC_BITS + 1);
      return ((num / den) + 1) >> 1;
   endfunction

   function automatic phase_result_type predict_phase(logic signed [SAMPLE_WIDTH-1:0] i_s,
                                                      logic signed [SAMPLE_WIDTH-1:0] q_s);
      phase_result_type r;
      longint           mag_i, mag_q, ratio, ang;
      bit               neg_i, neg_q;
      neg_i = i_s[SAMPLE_WIDTH-1];
      neg_q = q_s[SAMPLE_WIDTH-1];
      mag_i = neg_i ? -longint'(i_s) : longint'(i_s);
      mag_q = neg_q ? -longint'(q_s) : longint'(q_s);
      r.zero_vector = (mag_i == 0) && (mag_q == 0);
      if (r.zero_vector) begin
         r.angle = '0;
         return r;
      end
      if (mag_i < mag_q) begin
         ratio = octant_ratio(mag_q, mag_i);
         if (neg_i != neg_q) ratio = -ratio;
         ang = (neg_q ? -HALF_PI_ANGLE : HALF_PI_ANGLE) - ratio;
      end else begin
         ratio = octant_ratio(mag_i, mag_q);
         if (neg_i != neg_q) ratio = -ratio;
         // negative real axis lands on +pi
         if (!neg_i) ang = ratio;
         else if (!neg_q) ang = PI_ANGLE + ratio;
         else ang = ratio - PI_ANGLE;
      end
      if (ang > ANGLE_MAX) ang = ANGLE_MAX;
      if (ang < ANGLE_MIN) ang = ANGLE_MIN;
      r.angle = ang[ANGLE_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      phase_result_type want;
      bit               bad;
      if (!reset) begin
         if (req_tvalid && req_tready)
            angle_fifo.push_back(predict_phase(req_tdata[SAMPLE_WIDTH-1:0],
                                               req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
         if (rsp_tvalid && rsp_tready) begin
            if (angle_fifo.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: unexpected angle transfer %0d zero %0b",
                           $signed(rsp_tdata[ANGLE_W-1:0]), rsp_tuser);
            end else begin
               want = angle_fifo.pop_front();
               bad = 0;
               if (rsp_tdata[ANGLE_W-1:0] !== want.angle) begin
                  errors++;
                  bad = 1;
               end
               if (rsp_tuser !== want.zero_vector) begin
                  errors++;
                  bad = 1;
               end
               if (bad && errors <= 10)
                  $display("mismatch: angle exp %0d got %0d, zero_vector exp %0b got %0b",
                           $signed(want.angle), $signed(rsp_tdata[ANGLE_W-1:0]),
                           want.zero_vector, rsp_tuser);
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= angle_fifo.size();
   end

endmodule

// ===== test/testbench.sv =====
// top: clock, reset, sample pair stimulus with random idling, and the verdict
module testbench;

   localparam int SAMPLE_WIDTH = iqat_pkg::SAMPLE_WIDTH;
   localparam int REQ_DATA_W   = iqat_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W   = iqat_pkg::RSP_DATA_W;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PAIRS   = 1950;
   localparam int LONG_HOLD      = 120;
   localparam int DRAIN_CYCLES   = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   int mismatch_count;
   int pending_count;
   int pairs_sent       = 0;
   int angles_taken     = 0;
   int stalled_cycles   = 0;
   bit sender_streaming = 1'b0;

   always #5 clock = ~clock;

   iq_phase_atan2_approximation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   phase_checker phase_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // segments of 64 pairs: back to back, random gaps, mostly back to back
   task automatic send_pair(input logic signed [SAMPLE_WIDTH-1:0] i_s,
                            input logic signed [SAMPLE_WIDTH-1:0] q_s);
      int gap;
      case ((pairs_sent / 64) % 3)
         0: gap = 0;
         1: gap = $urandom_range(0, 17);
         default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      endcase
      sender_streaming = ((pairs_sent / 64) % 3 == 0);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {q_s, i_s};
      @(posedge clock);
      while (!(req_tvalid && req_tready)) @(posedge clock);
      pairs_sent++;
   endtask

   function automatic logic [2*SAMPLE_WIDTH-1:0] random_pair();
      logic signed [SAMPLE_WIDTH-1:0] i_s, q_s;
      i_s = SAMPLE_WIDTH'($urandom);
      q_s = SAMPLE_WIDTH'($urandom);
      case ($urandom_range(0, 5))
         2: begin
            i_s = SAMPLE_WIDTH'(int'($urandom_range(0, 30)) - 15);
            q_s = SAMPLE_WIDTH'(int'($urandom_range(0, 30)) - 15);
         end
         3: q_s = $urandom_range(0, 1) ? i_s : -i_s;
         4: begin
            if ($urandom_range(0, 1)) q_s = '0;
            else i_s = '0;
         end
         5: begin
            // on or just off the diagonal, either sign
            q_s = SAMPLE_WIDTH'(int'(i_s) + int'($urandom_range(0, 6)) - 3);
            if ($urandom_range(0, 1)) q_s = -q_s;
         end
         default: ;
      endcase
      return {q_s, i_s};
   endfunction

   initial begin : stimulus
      logic [2*SAMPLE_WIDTH-1:0] pair;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // zero vector, axes, corners
      send_pair(0, 0);
      send_pair(32767, 0);
      send_pair(-32768, 0);
      send_pair(0, 32767);
      send_pair(0, -32768);
      send_pair(-1, 0);
      send_pair(1, 0);
      send_pair(0, 1);
      send_pair(32767, 32767);
      send_pair(-32768, -32768);
      send_pair(-32768, 32767);
      send_pair(32767, -32768);
      // equal magnitudes in all four quadrants
      send_pair(5, 5);
      send_pair(-5, 5);
      send_pair(5, -5);
      send_pair(-5, -5);
      send_pair(-1, -1);
      // just off the axes in several octants, and one point on a diagonal
      send_pair(100, -3);
      send_pair(-3, 100);
      send_pair(-100, -1);
      send_pair(-100, 1);
      send_pair(3, -100);
      send_pair(-32768, -1);
      send_pair(-32767, 32767);
      send_pair(1, -32768);

      repeat (RANDOM_PAIRS) begin
         pair = random_pair();
         send_pair(pair[SAMPLE_WIDTH-1:0], pair[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : take_angles
      int hold;
      int long_holds;
      long_holds = 0;
      wait (!reset);
      forever begin
         // long back-pressure while the sender streams, to fill the pipeline
         if (sender_streaming && (pairs_sent % 64) < 20 && long_holds < 2 &&
             angles_taken >= 150 + 800 * long_holds) begin
            long_holds++;
            hold = LONG_HOLD;
         end else if ((angles_taken / 50) % 3 == 0) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 17);
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         angles_taken++;
      end
   end

endmodule
